// ----- hdl/fpfr_pkg.sv -----
// Package for the FIFO page-frame replacer.
// Holds field widths and the command and status types shared by the
// controller and the datapath. Depends on nothing.
package fpfr_pkg;

  localparam int unsigned OWNER_W = 7;
  localparam int unsigned STAMP_W = 31;
  localparam int unsigned INDEX_W = 3;

  typedef struct packed {
    logic load;    // Capture the page and clear the scan trackers.
    logic rd_en;   // Read the frame at the scan address and advance it.
    logic commit;  // Place the page and register the result.
  } fpfr_cmd_t;

  typedef struct packed {
    logic rd_last;  // The scan address points at the last frame.
  } fpfr_status_t;

endpackage

// ----- hdl/fpfr_if.sv -----
// Handshake interfaces for the page channel and the result channel.
// Depends on fpfr_pkg for the field widths.
interface fpfr_page_if import fpfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OWNER_W-1:0] owner_id;
  logic [STAMP_W-1:0] load_stamp;

  modport source (output valid, output owner_id, output load_stamp, input ready);
  modport sink (input valid, input owner_id, input load_stamp, output ready);
endinterface

interface fpfr_result_if import fpfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] frame_index;
  logic               evicted;
  logic [OWNER_W-1:0] evicted_owner;
  logic [STAMP_W-1:0] evicted_stamp;

  modport source (
    output valid, output frame_index, output evicted, output evicted_owner,
    output evicted_stamp, input ready
  );
  modport sink (
    input valid, input frame_index, input evicted, input evicted_owner,
    input evicted_stamp, output ready
  );
endinterface

// ----- hdl/fifo_page_frame_replacer.sv -----
// Top level of the FIFO page-frame replacer: joins controller and datapath.
// Depends on fpfr_pkg, fpfr_if, fpfr_ctrl and fpfr_datapath.
//
//   Channel   Dir   Payload                                           Role
//   page_if   in    owner_id, load_stamp                              page to place
//   res_if    out   frame_index, evicted, evicted_owner, evicted_stamp placement result
//
// An accepted page passes through a scan that reads each frame of the
// single-port frame memory in turn, a drain of the last registered read, a
// commit that writes the chosen frame and registers the result, and a state
// that presents the result. The next page is taken in the cycle after the
// result transfer. Reset empties every frame at once.
// A stalled result holds in its register and the page channel stays not ready.
module fifo_page_frame_replacer import fpfr_pkg::*; #(
  parameter int unsigned FRAME_COUNT = 8
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  fpfr_page_if.sink     page_if,
  fpfr_result_if.source res_if
);

  fpfr_cmd_t    cmd;
  fpfr_status_t status;

  fpfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (page_if.valid),
    .in_ready_o  (page_if.ready),
    .out_valid_o (res_if.valid),
    .out_ready_i (res_if.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  fpfr_datapath #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .owner_id_i      (page_if.owner_id),
    .load_stamp_i    (page_if.load_stamp),
    .frame_index_o   (res_if.frame_index),
    .evicted_o       (res_if.evicted),
    .evicted_owner_o (res_if.evicted_owner),
    .evicted_stamp_o (res_if.evicted_stamp)
  );

endmodule

// ----- hdl/fpfr_ctrl.sv -----
// Controller of the page-frame replacer: sequences accept, frame scan,
// commit and result transfer. Depends on fpfr_pkg.
module fpfr_ctrl import fpfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output fpfr_cmd_t    cmd_o,
  input  fpfr_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_OUTPUT
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (status_i.rd_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_OUTPUT;
      end
      ST_OUTPUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/fpfr_datapath.sv -----
// Datapath of the page-frame replacer: frame memory, occupancy bits,
// scan trackers for the first empty and the oldest full frame, and the
// result register. Depends on fpfr_pkg.
module fpfr_datapath import fpfr_pkg::*; #(
  parameter int unsigned FRAME_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fpfr_cmd_t          cmd_i,
  output fpfr_status_t       status_o,
  input  logic [OWNER_W-1:0] owner_id_i,
  input  logic [STAMP_W-1:0] load_stamp_i,
  output logic [INDEX_W-1:0] frame_index_o,
  output logic               evicted_o,
  output logic [OWNER_W-1:0] evicted_owner_o,
  output logic [STAMP_W-1:0] evicted_stamp_o
);

  localparam int unsigned IDX_W = $clog2(FRAME_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_COUNT - 1);

  logic [OWNER_W+STAMP_W-1:0] mem [FRAME_COUNT];
  logic [FRAME_COUNT-1:0]     full_q;

  logic [OWNER_W-1:0] owner_q;
  logic [STAMP_W-1:0] stamp_q;

  logic [IDX_W-1:0]           rd_addr_q;
  logic                       rd_vld_q;
  logic [IDX_W-1:0]           rd_idx_q;
  logic [OWNER_W+STAMP_W-1:0] rdata_q;
  logic [OWNER_W-1:0]         rd_owner;
  logic [STAMP_W-1:0]         rd_stamp;

  logic               found_empty_q;
  logic [IDX_W-1:0]   empty_idx_q;
  logic               seen_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [OWNER_W-1:0] best_owner_q;
  logic [STAMP_W-1:0] best_stamp_q;

  logic             rd_empty;
  logic [IDX_W-1:0] slot;

  assign rd_owner          = rdata_q[OWNER_W+STAMP_W-1:STAMP_W];
  assign rd_stamp          = rdata_q[STAMP_W-1:0];
  assign rd_empty          = !full_q[rd_idx_q];
  assign slot              = found_empty_q ? empty_idx_q : best_idx_q;
  assign status_o.rd_last  = (rd_addr_q == LAST_IDX);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr_q];
    end
    if (cmd_i.commit) begin
      mem[slot] <= {owner_q, stamp_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q        <= '0;
      rd_addr_q     <= '0;
      rd_vld_q      <= 1'b0;
      rd_idx_q      <= '0;
      found_empty_q <= 1'b0;
      seen_q        <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.rd_en) begin
        rd_idx_q  <= rd_addr_q;
        rd_addr_q <= rd_addr_q + 1'b1;
      end
      if (cmd_i.load) begin
        rd_addr_q     <= '0;
        found_empty_q <= 1'b0;
        seen_q        <= 1'b0;
      end else if (rd_vld_q) begin
        if (rd_empty) begin
          if (!found_empty_q) begin
            found_empty_q <= 1'b1;
          end
        end else if (!seen_q || (rd_stamp < best_stamp_q)) begin
          seen_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        full_q[slot] <= (owner_q != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      owner_q <= owner_id_i;
      stamp_q <= load_stamp_i;
    end
    if (rd_vld_q && !cmd_i.load) begin
      if (rd_empty) begin
        if (!found_empty_q) begin
          empty_idx_q <= rd_idx_q;
        end
      end else if (!seen_q || (rd_stamp < best_stamp_q)) begin
        best_idx_q   <= rd_idx_q;
        best_owner_q <= rd_owner;
        best_stamp_q <= rd_stamp;
      end
    end
    if (cmd_i.commit) begin
      frame_index_o   <= INDEX_W'(slot);
      evicted_o       <= !found_empty_q;
      evicted_owner_o <= found_empty_q ? '0 : best_owner_q;
      evicted_stamp_o <= found_empty_q ? '0 : best_stamp_q;
    end
  end

endmodule
